// File: hw/rtl/llci_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llci_pkg
// Shared types, codes and constant tables of the log-linear curve interpolator.
// ----------------------------------------------------------------------------
package llci_pkg;

  // Table geometry
  localparam int MAX_NODES = 16;
  localparam int ADDR_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);

  // Fixed-point geometry
  localparam int LOG_FRAC  = 24;
  localparam int EXP_STEPS = 24;
  localparam int DIV_STEPS = 16;

  // Item kinds
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_BEFORE = 3'd1;
  localparam logic [2:0] ST_BEYOND = 3'd2;
  localparam logic [2:0] ST_EMPTY  = 3'd3;
  localparam logic [2:0] ST_REJECT = 3'd4;

  // One stored node
  typedef struct packed {
    logic [31:0] horizon;
    logic [63:0] value;
    logic [31:0] lg2;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef logic [EXP_STEPS-1:0][31:0] exp2_tab_t;

  // Integer square root, bit pair at a time
  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bt;
    integer i;
    x   = x_in;
    res = 64'd0;
    bt  = 64'h4000_0000_0000_0000;
    for (i = 0; i < 32; i++) begin
      if (bt > x) bt = bt >> 2;
    end
    for (i = 0; i < 32; i++) begin
      if (bt != 64'd0) begin
        if (x >= res + bt) begin
          x   = x - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    return res;
  endfunction

  // Q1.31 factors 2^(2^-k), k = 1..24, by repeated square roots
  function automatic exp2_tab_t exp2_table();
    exp2_tab_t t;
    logic [63:0] c;
    integer k;
    c = isqrt64(64'h8000_0000_0000_0000);
    for (k = 0; k < EXP_STEPS; k++) begin
      t[k] = c[31:0];
      c    = isqrt64(c << 31);
    end
    return t;
  endfunction

  localparam exp2_tab_t EXP2_C = exp2_table();

endpackage

// File: hw/rtl/log_linear_curve_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_linear_curve_interpolator
// Node table in a RAM with a sequencer that appends, clears and answers
// queries by piecewise linear interpolation in log2 space.
// ----------------------------------------------------------------------------
// Steps: clear, unused kind, early reject and empty query go straight to the
//   emit state; append reads the RAM, runs the log2 unit and writes back.
// Query: the ends are answered from the first and last nodes; between nodes it
//   runs the node scan (one RAM read a cycle), the divider and the exp2 unit.
// Throughput: one transaction at a time; the next is taken once the result
//   has moved to the output register. Reset clears the count, not the RAM.
module log_linear_curve_interpolator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] horizon,
  input  logic [63:0] node_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] value_out,
  output logic [2:0]  status,
  output logic [4:0]  nodes_held
);

  localparam int AW = llci_pkg::ADDR_W;
  localparam int CW = llci_pkg::CNT_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_APP_CHK = 4'd1;
  localparam logic [3:0] S_APP_LOG = 4'd2;
  localparam logic [3:0] S_Q_FIRST = 4'd3;
  localparam logic [3:0] S_Q_LAST  = 4'd4;
  localparam logic [3:0] S_Q_SCAN  = 4'd5;
  localparam logic [3:0] S_DIV     = 4'd6;
  localparam logic [3:0] S_MIX     = 4'd7;
  localparam logic [3:0] S_EXP     = 4'd8;
  localparam logic [3:0] S_EMIT    = 4'd9;

  logic [3:0]  state;
  logic [CW-1:0] count;
  logic [AW-1:0] idx;
  logic [31:0] h_r;
  logic [63:0] v_r;
  llci_pkg::node_t prev;
  logic [31:0] cur_lg;
  logic signed [49:0] prod;
  logic [63:0] res_value;
  logic [2:0]  res_status;

  // RAM and unit hookup
  logic [AW-1:0]   raddr;
  llci_pkg::node_t rnode;
  logic [llci_pkg::NODE_W-1:0] rdata;
  llci_pkg::node_t wnode;
  logic            ram_we;
  logic            log_start, log_done;
  logic [31:0]     log_res;
  logic            div_start, div_done;
  logic [15:0]     div_q;
  logic            exp_start, exp_done;
  logic [63:0]     exp_res;
  logic [31:0]     div_num, div_den;
  logic signed [32:0] lg_diff;
  logic signed [33:0] mix_l;
  logic            accept;
  logic            out_free;

  assign rnode    = llci_pkg::node_t'(rdata);
  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Pick the RAM read address for the next cycle
  always_comb begin
    case (state)
      S_IDLE:    raddr = (kind == llci_pkg::KIND_APPEND) ? AW'(count - CW'(1)) : '0;
      S_Q_FIRST: raddr = AW'(count - CW'(1));
      S_Q_LAST:  raddr = AW'(1);
      S_Q_SCAN:  raddr = idx + AW'(1);
      default:   raddr = '0;
    endcase
  end

  assign wnode     = '{horizon: h_r, value: v_r, lg2: log_res};
  assign ram_we    = (state == S_APP_LOG) && log_done;
  assign log_start = (state == S_APP_CHK) &&
                     ((count == '0) || (h_r > rnode.horizon));
  assign div_start = (state == S_Q_SCAN) && (h_r < rnode.horizon);
  assign div_num   = h_r - prev.horizon;
  assign div_den   = rnode.horizon - prev.horizon;
  assign lg_diff   = signed'({cur_lg[31], cur_lg}) - signed'({prev.lg2[31], prev.lg2});
  assign mix_l     = signed'({{2{prev.lg2[31]}}, prev.lg2}) + prod[49:16];
  assign exp_start = (state == S_MIX);

  llci_ram #(
    .WIDTH(llci_pkg::NODE_W),
    .DEPTH(llci_pkg::MAX_NODES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(count)),
    .wdata(wnode),
    .raddr(raddr),
    .rdata(rdata)
  );

  llci_log2 u_log2 (
    .clk    (clk),
    .rst    (rst),
    .start  (log_start),
    .operand(v_r),
    .done   (log_done),
    .result (log_res)
  );

  llci_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_q)
  );

  llci_exp2 u_exp2 (
    .clk   (clk),
    .rst   (rst),
    .start (exp_start),
    .lg2   (mix_l[31:0]),
    .done  (exp_done),
    .result(exp_res)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_value  <= 64'd0;
            res_status <= llci_pkg::ST_OK;
            case (kind)
              llci_pkg::KIND_CLEAR: begin
                count <= '0;
                state <= S_EMIT;
              end
              llci_pkg::KIND_APPEND: begin
                if (node_value == 64'd0 || count >= CW'(llci_pkg::MAX_NODES)) begin
                  res_status <= llci_pkg::ST_REJECT;
                  state      <= S_EMIT;
                end else begin
                  state <= S_APP_CHK;
                end
              end
              llci_pkg::KIND_QUERY: begin
                if (count == '0) begin
                  res_status <= llci_pkg::ST_EMPTY;
                  state      <= S_EMIT;
                end else begin
                  state <= S_Q_FIRST;
                end
              end
              default: state <= S_EMIT;
            endcase
          end
        end
        S_APP_CHK: begin
          if (log_start) begin
            state <= S_APP_LOG;
          end else begin
            res_status <= llci_pkg::ST_REJECT;
            state      <= S_EMIT;
          end
        end
        S_APP_LOG: begin
          if (log_done) begin
            count <= count + CW'(1);
            state <= S_EMIT;
          end
        end
        S_Q_FIRST: begin
          prev <= rnode;
          if (h_r <= rnode.horizon) begin
            res_value  <= rnode.value;
            res_status <= (h_r < rnode.horizon) ? llci_pkg::ST_BEFORE : llci_pkg::ST_OK;
            state      <= S_EMIT;
          end else begin
            state <= S_Q_LAST;
          end
        end
        S_Q_LAST: begin
          if (h_r >= rnode.horizon) begin
            res_value  <= rnode.value;
            res_status <= (h_r > rnode.horizon) ? llci_pkg::ST_BEYOND : llci_pkg::ST_OK;
            state      <= S_EMIT;
          end else begin
            idx   <= AW'(1);
            state <= S_Q_SCAN;
          end
        end
        S_Q_SCAN: begin
          if (h_r == rnode.horizon) begin
            res_value <= rnode.value;
            state     <= S_EMIT;
          end else if (div_start) begin
            cur_lg <= rnode.lg2;
            state  <= S_DIV;
          end else begin
            prev <= rnode;
            idx  <= idx + AW'(1);
          end
        end
        S_DIV: begin
          if (div_done) begin
            prod  <= lg_diff * signed'({1'b0, div_q});
            state <= S_MIX;
          end
        end
        S_MIX: state <= S_EXP;
        S_EXP: begin
          if (exp_done) begin
            res_value <= exp_res;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Latch the transaction operands
  always_ff @(posedge clk) begin
    if (accept) begin
      h_r <= horizon;
      v_r <= node_value;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      value_out  <= res_value;
      status     <= res_status;
      nodes_held <= 5'(count);
    end
  end

  // Node count stays within the table
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(llci_pkg::MAX_NODES))
    else $error("node count exceeds table size");

  // Count only grows by one or clears
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (count == $past(count) + CW'(1)) || (count == '0))
    else $error("node count jumped");

  // Units finish only while the sequencer waits on them
  a_log_wait: assert property (@(posedge clk) disable iff (rst)
    log_done |-> state == S_APP_LOG)
    else $error("log2 done outside append");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider done outside weight step");

  a_exp_wait: assert property (@(posedge clk) disable iff (rst)
    exp_done |-> state == S_EXP)
    else $error("exp2 done outside exp step");

endmodule

// File: hw/rtl/llci_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llci_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module llci_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/llci_log2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llci_log2
// Iterative base-2 log of a nonzero Q48.16 value into signed Q7.24,
// one fraction bit per cycle by repeated squaring.
// ----------------------------------------------------------------------------
module llci_log2 (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] operand,
  output logic        done,
  output logic [31:0] result
);

  localparam int LOG_STEPS_LAST = llci_pkg::LOG_FRAC - 1;

  logic        busy;
  logic        norm;
  logic [4:0]  step;
  logic [5:0]  top;
  logic [63:0] val;
  logic [31:0] x;
  logic [23:0] frac;

  logic [5:0]  top_next;
  logic [63:0] shifted;
  logic [63:0] sq;
  logic [32:0] sq_sh;

  // Find the leading one
  always_comb begin
    top_next = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (operand[i]) top_next = 6'(i);
    end
  end

  // Normalize to Q1.31 and square
  assign shifted = val << (6'd63 - top);
  assign sq      = 64'(x) * 64'(x);
  assign sq_sh   = sq[63:31];

  // Control: normalize, then one squaring per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      norm <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        norm <= 1'b1;
      end else if (norm) begin
        norm <= 1'b0;
        busy <= 1'b1;
      end else if (busy && step == 5'(LOG_STEPS_LAST)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      top <= top_next;
      val <= operand;
    end else if (norm) begin
      x    <= shifted[63:32];
      step <= 5'd0;
      frac <= 24'd0;
    end else if (busy) begin
      step <= step + 5'd1;
      if (sq_sh[32]) begin
        x    <= sq_sh[32:1];
        frac <= {frac[22:0], 1'b1};
      end else begin
        x    <= sq_sh[31:0];
        frac <= {frac[22:0], 1'b0};
      end
    end
  end

  assign result = {8'({2'b00, top}) - 8'd16, frac};

endmodule

// File: hw/rtl/llci_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llci_div
// Restoring divider for the Q0.16 weight (num << 16) / den, num < den,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module llci_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [15:0] quot
);

  localparam int STEP_LAST = llci_pkg::DIV_STEPS - 1;

  logic        busy;
  logic [3:0]  step;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [32:0] rem2;
  logic        fits;

  assign rem2 = {rem, 1'b0};
  assign fits = rem2 >= {1'b0, dvs};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == 4'(STEP_LAST)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Shift, compare, subtract
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dvs  <= den;
      step <= 4'd0;
    end else if (busy) begin
      step <= step + 4'd1;
      quot <= {quot[14:0], fits};
      rem  <= fits ? 32'(rem2 - {1'b0, dvs}) : rem2[31:0];
    end
  end

endmodule

// File: hw/rtl/llci_exp2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llci_exp2
// Iterative exp2 of a signed Q7.24 log into unsigned Q48.16: one constant
// factor per fraction bit, then a final shift by the integer part.
// ----------------------------------------------------------------------------
module llci_exp2 (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] lg2,
  output logic        done,
  output logic [63:0] result
);

  localparam int STEP_LAST = llci_pkg::EXP_STEPS - 1;

  logic        busy;
  logic        fin;
  logic [4:0]  step;
  logic [31:0] m;
  logic [23:0] f;
  logic [7:0]  n;

  logic signed [32:0] e;
  logic [63:0]        prod;
  logic [63:0]        shifted;

  // Bias the log by sixteen, clamp at zero
  assign e    = signed'({lg2[31], lg2}) + 33'sd268435456;
  assign prod = 64'(m) * 64'(llci_pkg::EXP2_C[step]);

  // Scale by the integer part
  always_comb begin
    if (n >= 8'd63) begin
      shifted = '1;
    end else if (n >= 8'd31) begin
      shifted = 64'(m) << (n - 8'd31);
    end else begin
      shifted = 64'(m) >> (8'd31 - n);
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == 5'(STEP_LAST)) begin
        busy <= 1'b0;
        fin  <= 1'b1;
      end else if (fin) begin
        done <= 1'b1;
      end
    end
  end

  // Mantissa iteration and final shift
  always_ff @(posedge clk) begin
    if (start) begin
      m    <= 32'h8000_0000;
      step <= 5'd0;
      if (e[32]) begin
        n <= 8'd0;
        f <= 24'd0;
      end else begin
        n <= e[31:24];
        f <= e[23:0];
      end
    end else if (busy) begin
      step <= step + 5'd1;
      f    <= {f[22:0], 1'b0};
      if (f[23]) m <= prod[62:31];
    end else if (fin) begin
      result <= shifted;
    end
  end

endmodule
